>>> hw/rtl/ps2kt_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard transmitter package
// Item types, operation codes, the front-to-back command and frame helpers.
// ----------------------------------------------------------------------------
package ps2kt_pkg;

    // Default byte queue depth
    localparam int QUEUE_DEPTH_DEF = 16;

    // Operation codes of an input item
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_MAKE  = 2'd1;
    localparam logic [1:0] OP_BREAK = 2'd2;

    // Line data select codes carried with a tick command
    localparam logic [1:0] DSEL_ZERO  = 2'd0;
    localparam logic [1:0] DSEL_HOLD  = 2'd1;
    localparam logic [1:0] DSEL_FRAME = 2'd2;

    localparam logic [7:0] BREAK_BYTE = 8'hF0;
    localparam logic [3:0] FRAME_BITS = 4'd11;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] scancode;
    } t_in_item;

    typedef struct packed {
        logic line_clock;
        logic line_data;
        logic queue_overflow;
    } t_out_item;

    // One command from the front to the back: either a tick or a byte write burst
    typedef struct packed {
        logic            is_tick;
        logic            load;       // tick pops the head byte into the frame
        logic            clk;        // line clock after this tick
        logic [1:0]      dsel;       // line data source
        logic [3:0]      bit_idx;    // frame bit for DSEL_FRAME
        logic            ovf;        // overflow flag seen by this tick
        logic [1:0]      nbytes;     // bytes to write, 1 to 3
        logic [2:0][7:0] bytes;      // bytes in queue order, entry 0 first
    } t_cmd;

    // Bit of the 11-bit frame: start 0, data LSB first, odd parity, stop 1
    function automatic logic frame_bit(input logic [7:0] b, input logic [3:0] idx);
        logic bit_val;
        bit_val = 1'b0;
        case (idx) inside
            4'd0:          bit_val = 1'b0;
            [4'd1:4'd8]:   bit_val = b[3'(idx - 4'd1)];
            4'd9:          bit_val = ~^b;
            4'd10:         bit_val = 1'b1;
            default:       bit_val = 1'b0;
        endcase
        return bit_val;
    endfunction

endpackage

>>> hw/rtl/ps2kt_front.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard transmitter front
// Classifies items, keeps the byte count, overflow flag and line timing, and
// issues in-order commands to the back.
// ----------------------------------------------------------------------------
module ps2kt_front
    import ps2kt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_item i_item,
    output logic     o_cmd_push,
    output t_cmd     o_cmd
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_busy, n_busy;
    logic [3:0]    r_bit_idx, n_bit_idx;
    logic          r_clk, n_clk;

    logic [7:0] prefix;
    logic [7:0] code;
    logic       has_pre;
    logic       is_brk;
    logic [1:0] need;
    logic       fits;
    logic       load;
    logic       busy_l;
    logic [3:0] idx_l;

    // Classify the item and size its byte sequence
    always_comb begin
        prefix  = i_item.scancode[15:8];
        code    = i_item.scancode[7:0];
        has_pre = (prefix != 8'd0);
        is_brk  = (i_item.operation == OP_BREAK);
        need    = 2'(has_pre) + (is_brk ? 2'd2 : 2'd1);
        fits    = ({1'b0, r_count} + (CW+1)'(need)) <= (CW+1)'(QUEUE_DEPTH);
        load    = !r_busy && (r_count != '0);
        busy_l  = r_busy || load;
        idx_l   = load ? 4'd0 : r_bit_idx;
    end

    // Advance the model state and build the command
    always_comb begin
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_busy     = r_busy;
        n_bit_idx  = r_bit_idx;
        n_clk      = r_clk;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (i_take) begin
            unique case (i_item.operation) inside
                OP_TICK: begin
                    o_cmd_push    = 1'b1;
                    o_cmd.is_tick = 1'b1;
                    o_cmd.load    = load;
                    o_cmd.ovf     = r_ovf;
                    n_count       = r_count - CW'(load);
                    if (busy_l && (idx_l < FRAME_BITS)) begin
                        n_busy = 1'b1;
                        n_clk  = ~r_clk;
                        if (r_clk) begin
                            o_cmd.dsel    = DSEL_FRAME;
                            o_cmd.bit_idx = idx_l;
                            n_bit_idx     = idx_l + 4'd1;
                        end else begin
                            o_cmd.dsel = DSEL_HOLD;
                            n_bit_idx  = idx_l;
                        end
                    end else begin
                        n_busy     = 1'b0;
                        n_clk      = 1'b1;
                        n_bit_idx  = idx_l;
                        o_cmd.dsel = DSEL_ZERO;
                    end
                    o_cmd.clk = n_clk;
                end
                OP_MAKE, OP_BREAK: begin
                    if (fits) begin
                        o_cmd_push   = 1'b1;
                        o_cmd.nbytes = need;
                        n_count      = r_count + CW'(need);
                        if (has_pre) begin
                            o_cmd.bytes[0] = prefix;
                            o_cmd.bytes[1] = is_brk ? BREAK_BYTE : code;
                            o_cmd.bytes[2] = code;
                        end else begin
                            o_cmd.bytes[0] = is_brk ? BREAK_BYTE : code;
                            o_cmd.bytes[1] = code;
                            o_cmd.bytes[2] = code;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_busy    <= 1'b0;
            r_bit_idx <= 4'd0;
            r_clk     <= 1'b1;
        end else begin
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_busy    <= n_busy;
            r_bit_idx <= n_bit_idx;
            r_clk     <= n_clk;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("byte count above queue depth");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared without reset");

    a_idle_clock_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_clk)
        else $error("line clock low while idle");

    a_load_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_push && o_cmd.load) |=> (r_busy && r_bit_idx == 4'd1 && !r_clk))
        else $error("frame load did not start with a falling edge");

endmodule

>>> hw/rtl/ps2kt_cmd_fifo.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard transmitter command queue
// Two-entry queue of commands between the front and the back.
// ----------------------------------------------------------------------------
module ps2kt_cmd_fifo
    import ps2kt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_q [2];
    t_cmd       n_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic [1:0] cnt_after_pop;
    logic       do_pop;
    logic       do_push;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[0];

    // Shift on pop, place the new item behind the survivors
    always_comb begin
        do_pop        = i_pop && o_valid;
        do_push       = i_push && !o_full;
        cnt_after_pop = r_cnt - 2'(do_pop);
        n_q[0]        = r_q[0];
        n_q[1]        = r_q[1];
        if (do_pop) begin
            n_q[0] = r_q[1];
        end
        if (do_push) begin
            n_q[cnt_after_pop[0]] = i_cmd;
        end
        n_cnt = cnt_after_pop + 2'(do_push);
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

>>> hw/rtl/ps2kt_back.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard transmitter back
// Holds the byte memory, writes queued bytes, loads frames on ticks and
// drives line levels into a two-entry result queue.
// ----------------------------------------------------------------------------
module ps2kt_back
    import ps2kt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);

    logic [7:0]    r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_head, r_tail;
    logic [1:0]    r_sub;
    logic [7:0]    r_byte;
    logic          r_data;
    t_out_item     r_oq [2];
    t_out_item     n_oq [2];
    logic [1:0]    r_ocnt, n_ocnt;

    logic          out_pop;
    logic          out_room;
    logic          tick_go;
    logic          wr_go;
    logic          wr_last;
    logic [7:0]    wr_byte;
    logic          n_data;
    t_out_item     result;
    logic [1:0]    ocnt_after_pop;

    function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + AW'(1);
    endfunction

    // Decide what the head command does this cycle
    always_comb begin
        out_pop   = i_pop && (r_ocnt != 2'd0);
        out_room  = (r_ocnt != 2'd2);
        tick_go   = i_cmd_valid && i_cmd.is_tick && out_room;
        wr_go     = i_cmd_valid && !i_cmd.is_tick;
        wr_last   = (r_sub == i_cmd.nbytes - 2'd1);
        o_cmd_pop = tick_go || (wr_go && wr_last);
        wr_byte   = i_cmd.bytes[r_sub];
    end

    // Select the line data level
    always_comb begin
        unique case (i_cmd.dsel)
            DSEL_ZERO:  n_data = 1'b0;
            DSEL_HOLD:  n_data = r_data;
            DSEL_FRAME: n_data = frame_bit(r_byte, i_cmd.bit_idx);
            default:    n_data = 1'b0;
        endcase
        result.line_clock     = i_cmd.clk;
        result.line_data      = n_data;
        result.queue_overflow = i_cmd.ovf;
    end

    // Result queue: shift on pop, append behind the survivors
    always_comb begin
        ocnt_after_pop = r_ocnt - 2'(out_pop);
        n_oq[0]        = r_oq[0];
        n_oq[1]        = r_oq[1];
        if (out_pop) begin
            n_oq[0] = r_oq[1];
        end
        if (tick_go) begin
            n_oq[ocnt_after_pop[0]] = result;
        end
        n_ocnt = ocnt_after_pop + 2'(tick_go);
    end

    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_oq[0];

    // Byte memory write and registered head read
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_tail] <= wr_byte;
        end
        if (tick_go && i_cmd.load) begin
            r_byte <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        r_oq[0] <= n_oq[0];
        r_oq[1] <= n_oq[1];
        if (tick_go) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_sub  <= 2'd0;
            r_ocnt <= 2'd0;
        end else begin
            r_ocnt <= n_ocnt;
            if (tick_go && i_cmd.load) begin
                r_head <= next_ptr(r_head);
            end
            if (wr_go) begin
                r_tail <= next_ptr(r_tail);
                r_sub  <= wr_last ? 2'd0 : r_sub + 2'd1;
            end
        end
    end

    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2)
        else $error("result queue count out of range");

    a_sub_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != 2'd0) |-> (i_cmd_valid && !i_cmd.is_tick && r_sub < i_cmd.nbytes))
        else $error("byte burst step without a write command");

endmodule

>>> hw/rtl/ps2_keyboard_transmitter_top.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard transmitter top
// Device side of a PS/2 keyboard link: key items queue scancode bytes, tick
// items drive the line one half-period at a time.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  input     in         push / full            i_item   (operation, scancode)
//  result    out        empty / pop            o_result (line levels, overflow)
//
//  One item is accepted per cycle while full is low; a tick's result passes
//  through the command queue and then the result queue to the result ports.
//  Make and break items hold the back while their one to three bytes go
//  one by one through the single write port of the byte memory; the command
//  queue absorbs them. Reset is synchronous and needs no clearing pass.
//  A stalled result side fills the two-entry result queue, then the command
//  queue, then raises full.
// ----------------------------------------------------------------------------
module ps2_keyboard_transmitter_top
    import ps2kt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic take;
    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_full;
    logic cmd_valid;
    t_cmd cmd_out;
    logic cmd_pop;

    assign full = cmd_full;
    assign take = push && !cmd_full;

    // Classify items and track the line timing
    ps2kt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_item     (i_item),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // Decouple front and back
    ps2kt_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out)
    );

    // Store bytes, load frames and produce results
    ps2kt_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

>>> test/ps2_keyboard_transmitter_top_tb.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard transmitter testbench
// Drives make, break and tick items through the push/full side and checks
// every tick's line levels and overflow flag against a cycle-free line model.
// A directed opening covers prefixes, the break byte, the unused operation,
// a queue filled to the brim and a dropped sequence. Random key bursts and
// tick runs follow, under changing idle rates and one long result stall.
// ----------------------------------------------------------------------------
module ps2_keyboard_transmitter_top_tb
    import ps2kt_pkg::*;
;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1080;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         STALL_AT     = 250;
    localparam int         STALL_LEN    = 300;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      full;
    t_in_item  i_item  = '0;
    logic      empty;
    logic      pop     = 1'b0;
    t_out_item o_result;

    ps2_keyboard_transmitter_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    // Clock: period 8
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Line model state
    logic [7:0]  key_bytes[$];
    logic [10:0] frame_bits  = '0;
    logic [3:0]  frame_pos   = '0;
    logic        line_busy   = 1'b0;
    logic        clk_level   = 1'b1;
    logic        data_level  = 1'b0;
    logic        ovf_sticky  = 1'b0;

    t_in_item  key_items[$];
    t_out_item line_levels_due[$];

    int items_sent   = 0;
    int total_items  = 0;
    int results_seen = 0;
    int errors       = 0;
    int cycles       = 0;
    int stall_left   = 0;
    bit stall_done   = 1'b0;

    // Idle rates: sender light/receiver heavy, then swapped, then none
    wire [1:0] idle_phase = (items_sent < total_items / 3)     ? 2'd0 :
                            (items_sent < 2 * total_items / 3) ? 2'd1 : 2'd2;

    // Advance the line model by one accepted item
    task automatic line_model_step(input t_in_item it);
        logic [7:0] prefix;
        logic [7:0] b;
        int         need;
        prefix = it.scancode[15:8];
        case (it.operation)
            OP_MAKE, OP_BREAK: begin
                need = (prefix != 8'h00) + ((it.operation == OP_BREAK) ? 2 : 1);
                if (key_bytes.size() + need > QUEUE_DEPTH_DEF) begin
                    ovf_sticky = 1'b1;
                end else begin
                    if (prefix != 8'h00) key_bytes.push_back(prefix);
                    if (it.operation == OP_BREAK) key_bytes.push_back(BREAK_BYTE);
                    key_bytes.push_back(it.scancode[7:0]);
                end
            end
            OP_TICK: begin
                // Load the next byte onto an idle line
                if (!line_busy && key_bytes.size() != 0) begin
                    b          = key_bytes.pop_front();
                    frame_bits = {1'b1, ~^b, b, 1'b0};
                    frame_pos  = '0;
                    line_busy  = 1'b1;
                end
                if (line_busy && frame_pos < FRAME_BITS) begin
                    clk_level = ~clk_level;
                    if (!clk_level) begin
                        data_level = frame_bits[frame_pos];
                        frame_pos  = frame_pos + 4'd1;
                    end
                end else begin
                    clk_level  = 1'b1;
                    data_level = 1'b0;
                    line_busy  = 1'b0;
                end
                line_levels_due.push_back('{line_clock: clk_level, line_data: data_level,
                                            queue_overflow: ovf_sticky});
            end
            default: ;
        endcase
    endtask

    // Driver: hold the item while full, then offer the next one or idle
    always @(posedge i_clk) begin : drive_proc
        bit idle;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || !full) begin
            if (push) begin
                line_model_step(i_item);
                items_sent++;
            end
            case (idle_phase)
                2'd0:    idle = ($urandom_range(0, 99) < 13);
                2'd1:    idle = ($urandom_range(0, 99) < 63);
                default: idle = 1'b0;
            endcase
            if (key_items.size() != 0 && !idle) begin
                push   <= 1'b1;
                i_item <= key_items.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: check each popped result against the oldest expectation
    always @(posedge i_clk) begin : watch_proc
        t_out_item want;
        bit        idle;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (line_levels_due.size() == 0) begin
                    $display("%0t: unexpected result expected none got %b", $time, o_result);
                    errors++;
                end else begin
                    want = line_levels_due.pop_front();
                    if (o_result.line_clock !== want.line_clock) begin
                        $display("%0t: line_clock expected %0b got %0b", $time,
                                 want.line_clock, o_result.line_clock);
                        errors++;
                    end
                    if (o_result.line_data !== want.line_data) begin
                        $display("%0t: line_data expected %0b got %0b", $time,
                                 want.line_data, o_result.line_data);
                        errors++;
                    end
                    if (o_result.queue_overflow !== want.queue_overflow) begin
                        $display("%0t: queue_overflow expected %0b got %0b", $time,
                                 want.queue_overflow, o_result.queue_overflow);
                        errors++;
                    end
                end
            end
            // Hold off once for a long stretch so the block backs up
            if (!stall_done && results_seen >= STALL_AT) begin
                stall_done = 1'b1;
                stall_left = STALL_LEN;
            end
            if (stall_left > 0) stall_left--;
            case (idle_phase)
                2'd0:    idle = ($urandom_range(0, 99) < 63);
                2'd1:    idle = ($urandom_range(0, 99) < 13);
                default: idle = 1'b0;
            endcase
            pop <= (stall_left == 0) && !idle;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin : stim_proc
        int       n;
        int       burst;
        int       r;
        t_in_item it;

        // Directed: prefixes, break byte, unused op, extremes, full queue, drop
        key_items.push_back('{OP_MAKE,   16'h001C});
        key_items.push_back('{OP_MAKE,   16'hE075});
        key_items.push_back('{OP_UNUSED, 16'hABCD});
        repeat (4) key_items.push_back('{OP_TICK, 16'h0000});
        key_items.push_back('{OP_BREAK,  16'h001C});
        key_items.push_back('{OP_BREAK,  16'hE075});
        key_items.push_back('{OP_MAKE,   16'hFFFF});
        key_items.push_back('{OP_BREAK,  16'h0000});
        key_items.push_back('{OP_BREAK,  16'hE011});
        key_items.push_back('{OP_MAKE,   16'hE012});
        key_items.push_back('{OP_MAKE,   16'h0013});
        repeat (8) key_items.push_back('{OP_TICK, 16'hFFFF});

        // Random: key bursts and tick runs, with a little noise
        n = 0;
        while (n < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                key_items.push_back('{OP_UNUSED, 16'($urandom)});
            end else if (r < 30) begin
                burst = $urandom_range(1, 5);
                repeat (burst) begin
                    it.operation = $urandom_range(0, 1) ? OP_BREAK : OP_MAKE;
                    r = $urandom_range(0, 3);
                    it.scancode[15:8] = (r < 2) ? 8'h00 : (r == 2) ? 8'hE0 : 8'($urandom);
                    it.scancode[7:0]  = 8'($urandom);
                    key_items.push_back(it);
                    n++;
                end
            end else begin
                burst = $urandom_range(1, 100);
                repeat (burst) begin
                    key_items.push_back('{OP_TICK, 16'($urandom)});
                    n++;
                end
            end
        end
        total_items = key_items.size();

        // Release reset after the opening wait
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all items in, all results out, then a short settle
        @(posedge i_clk);
        while (key_items.size() != 0 || push) @(posedge i_clk);
        while (line_levels_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (line_levels_due.size() != 0) begin
            $display("%0t: results missing expected %0d got 0", $time, line_levels_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
